### rtl/first_fit_block_allocator_defines.svh
// Assertion macros shared by the allocator files.
`ifndef FIRST_FIT_BLOCK_ALLOCATOR_DEFINES_SVH
`define FIRST_FIT_BLOCK_ALLOCATOR_DEFINES_SVH

// Same-cycle implication, checked at every rising edge outside reset.
`define FFBA_ASSERT_SAME(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, checked at every rising edge outside reset.
`define FFBA_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

### rtl/ffba_pkg.sv
package ffba_pkg;

  localparam int MAX_BLOCKS_DEF   = 16;
  localparam int SIZE_BITS_DEF    = 16;
  localparam int INDEX_W          = 4;
  localparam int VALUE_W          = 16;
  localparam int STATUS_W         = 2;
  localparam int NUM_BLOCKS_W     = 5;

  localparam logic [NUM_BLOCKS_W-1:0] NUM_BLOCKS_RESET = 5'd16;

  localparam logic OP_LOAD    = 1'b0;
  localparam logic OP_REQUEST = 1'b1;

  localparam logic [STATUS_W-1:0] ST_LOADED        = 2'd0;
  localparam logic [STATUS_W-1:0] ST_ALLOCATED     = 2'd1;
  localparam logic [STATUS_W-1:0] ST_NOT_ALLOCATED = 2'd2;
  localparam logic [STATUS_W-1:0] ST_UNUSED        = 2'd3;

  // One request as it travels along the chain of cells.
  typedef struct packed {
    logic               valid;
    logic               op;
    logic [INDEX_W-1:0] blk_idx;
    logic [VALUE_W-1:0] size;
    logic               granted;
    logic [INDEX_W-1:0] grant_idx;
  } ffba_token_t;

endpackage

### rtl/first_fit_block_allocator.sv
// Channel   Direction  Handshake                 Payload
// request   in         in_valid_i / in_ready_o   operation_i, block_index_i, size_value_i
// result    out        out_valid_o / out_ready_i status_o, granted_block_o
// config    in         cfg_we_i (no wait)        cfg_wdata_i (num_blocks)
//
// Throughput is one request per cycle while the chain is not stalled. A request is captured by
// the first cell at the accepting edge, then passes through each later cell register and the
// output register before the result is valid.
// Reset (rst_ni low, asynchronous) clears every block size to zero, empties the chain
// and sets num_blocks to 16.
// A result that is not taken stalls the whole chain; in_ready_o drops in the same cycle.
`include "first_fit_block_allocator_defines.svh"

module first_fit_block_allocator #(
  parameter int MaxBlocks = ffba_pkg::MAX_BLOCKS_DEF,
  parameter int SizeBits  = ffba_pkg::SIZE_BITS_DEF
) (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           cfg_we_i,
  input  logic [ffba_pkg::NUM_BLOCKS_W-1:0] cfg_wdata_i,
  input  logic                           in_valid_i,
  output logic                           in_ready_o,
  input  logic                           operation_i,
  input  logic [ffba_pkg::INDEX_W-1:0]   block_index_i,
  input  logic [ffba_pkg::VALUE_W-1:0]   size_value_i,
  output logic                           out_valid_o,
  input  logic                           out_ready_i,
  output logic [ffba_pkg::STATUS_W-1:0]  status_o,
  output logic [ffba_pkg::INDEX_W-1:0]   granted_block_o
);
  import ffba_pkg::*;

  // Each cell owns one block's remaining size. Requests walk the chain in order,
  // one cell per cycle when not stalled, so a request always meets each cell after every older
  // request has already updated it: first-fit order is kept with no hazard check.

  logic [NUM_BLOCKS_W-1:0] num_blocks_q;
  logic                    adv;
  ffba_token_t             tok_in;
  ffba_token_t             chain [MaxBlocks+1];
  ffba_token_t             tok_last;

  logic                    out_valid_q;
  logic [STATUS_W-1:0]     status_q, status_d;
  logic [INDEX_W-1:0]      granted_q, granted_d;

  // The whole chain moves together whenever the output register can take a result.
  assign adv        = !out_valid_q || out_ready_i;
  assign in_ready_o = adv;

  // The user must write configuration only while the chain is empty; the block does not enforce this.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      num_blocks_q <= NUM_BLOCKS_RESET;
    end else if (cfg_we_i) begin
      num_blocks_q <= cfg_wdata_i;
    end
  end

  always_comb begin
    tok_in           = '0;
    tok_in.valid     = in_valid_i;
    tok_in.op        = operation_i;
    tok_in.blk_idx   = block_index_i;
    tok_in.size      = size_value_i;
    tok_in.granted   = 1'b0;
    tok_in.grant_idx = '0;
  end

  assign chain[0] = tok_in;

  for (genvar k = 0; k < MaxBlocks; k++) begin : g_cell
    logic active;
    // Only the first num_blocks cells take part in the search.
    assign active = 32'(num_blocks_q) > 32'(k);

    ffba_cell #(
      .CellIdx (k),
      .SizeBits(SizeBits)
    ) u_cell (
      .clk_i   (clk_i),
      .rst_ni  (rst_ni),
      .adv_i   (adv),
      .active_i(active),
      .tok_i   (chain[k]),
      .tok_o   (chain[k+1])
    );
  end

  assign tok_last = chain[MaxBlocks];

  // Turn the token leaving the last cell into a result.
  always_comb begin
    granted_d = '0;
    if (tok_last.op == OP_LOAD) begin
      status_d = ST_LOADED;
    end else if (tok_last.granted) begin
      status_d  = ST_ALLOCATED;
      granted_d = tok_last.grant_idx;
    end else begin
      status_d = ST_NOT_ALLOCATED;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (adv) begin
      out_valid_q <= tok_last.valid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      status_q  <= status_d;
      granted_q <= granted_d;
    end
  end

  assign out_valid_o     = out_valid_q;
  assign status_o        = status_q;
  assign granted_block_o = granted_q;

  `FFBA_ASSERT_SAME(a_status_code, clk_i, rst_ni, out_valid_o, status_o != ST_UNUSED,
                    "result carries an unused status code")
  `FFBA_ASSERT_SAME(a_load_grant_zero, clk_i, rst_ni,
                    out_valid_o && (status_o != ST_ALLOCATED), granted_block_o == '0,
                    "non-allocated result carries a block index")
  `FFBA_ASSERT_SAME(a_grant_in_range, clk_i, rst_ni,
                    out_valid_o && (status_o == ST_ALLOCATED),
                    32'(granted_block_o) < 32'(num_blocks_q),
                    "granted block lies outside the searched range")

endmodule

### rtl/ffba_cell.sv
`include "first_fit_block_allocator_defines.svh"

module ffba_cell #(
  parameter int CellIdx  = 0,
  parameter int SizeBits = 16
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 adv_i,
  input  logic                 active_i,
  input  ffba_pkg::ffba_token_t tok_i,
  output ffba_pkg::ffba_token_t tok_o
);
  import ffba_pkg::*;

  logic [SizeBits-1:0] rem_q, rem_d;
  logic [SizeBits-1:0] in_size;
  ffba_token_t         tok_q, tok_d;

  // Loads address this cell by index; a request is granted here when no
  // earlier cell took it, the cell is active and the remaining size covers it.
  always_comb begin
    tok_d   = tok_i;
    rem_d   = rem_q;
    in_size = SizeBits'(tok_i.size);
    if (tok_i.valid) begin
      if (tok_i.op == OP_LOAD) begin
        if (32'(tok_i.blk_idx) == 32'(CellIdx)) begin
          rem_d = in_size;
        end
      end else if (!tok_i.granted && active_i && (rem_q >= in_size)) begin
        rem_d           = rem_q - in_size;
        tok_d.granted   = 1'b1;
        tok_d.grant_idx = INDEX_W'(CellIdx);
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rem_q <= '0;
      tok_q <= '0;
    end else if (adv_i) begin
      rem_q <= rem_d;
      tok_q <= tok_d;
    end
  end

  assign tok_o = tok_q;

  `FFBA_ASSERT_NEXT(a_stall_holds_rem, clk_i, rst_ni, !adv_i, $stable(rem_q),
                    "cell size changed during a stall")
  `FFBA_ASSERT_NEXT(a_stall_holds_tok, clk_i, rst_ni, !adv_i, $stable(tok_q),
                    "cell token changed during a stall")
  `FFBA_ASSERT_NEXT(a_grant_kept, clk_i, rst_ni,
                    adv_i && tok_i.valid && tok_i.granted,
                    tok_q.granted && (tok_q.grant_idx == $past(tok_i.grant_idx))
                    && ($past(rem_q) == rem_q),
                    "an earlier grant was altered by a later cell")

endmodule
